[design/sync_header_length_framer_assert.svh]
// Assertion macros used by the framer engine module.
`ifndef SYNC_HEADER_LENGTH_FRAMER_ASSERT_SVH
`define SYNC_HEADER_LENGTH_FRAMER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SHLF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define SHLF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[design/shlf_pkg.sv]
// Types and constants for the sync header length framer.
package shlf_pkg;

  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned HC_W         = 3;

  localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
  localparam logic [15:0] LEN_EXTRA    = 16'd2;

  localparam logic [7:0]  LOCAL_ADDR_RST   = 8'd255;
  localparam logic [7:0]  DOWN_ADDR_RST    = 8'd255;
  localparam logic [15:0] TIMEOUT_RST      = 16'd3000;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_LOCAL_ADDR = 2'd0,
    REG_DOWN_ADDR  = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEAD = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_SYNC    = 3'd1,
    ST_HEADER  = 3'd2,
    ST_DATA    = 3'd3,
    ST_DONE    = 3'd4,
    ST_REJECT  = 3'd5,
    ST_TIMEOUT = 3'd6
  } status_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } shlf_in_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  byte_out;
    logic [15:0] frame_length;
  } shlf_out_t;

  typedef struct packed {
    logic [7:0]  local_address;
    logic [7:0]  down_address;
    logic [15:0] timeout_ticks;
  } shlf_cfg_t;

endpackage

[design/sync_header_length_framer.sv]
// Throughput: one beat per cycle, bytes and ticks alike; only out_ready stalls it.
// Input register feeds the frame engine, whose step writes the result register for out_valid.
// Reset (rst_n low, synchronous) empties both registers, idles the engine with its
// timer disarmed and restores local/down address 255 and a 3000 tick timeout.
module sync_header_length_framer
  import shlf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  shlf_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output shlf_out_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  shlf_cfg_t cfg;

  // input stage: holds one beat for the engine
  logic      s1_valid_r;
  shlf_in_t  s1_item_r;
  // result stage: holds one finished beat for the consumer
  logic      out_valid_r;
  shlf_out_t out_data_r;

  logic      out_free;
  logic      step_en;
  shlf_out_t result;

  // result slot can take a beat when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  // input slot refills when empty or when its beat moves on to the engine
  assign in_ready = !s1_valid_r || out_free;
  // the engine steps (and updates its state) exactly when a beat moves forward
  assign step_en  = s1_valid_r && out_free;

  shlf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shlf_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  // payload flops, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r <= in_data;
    if (step_en) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/shlf_cfg.sv]
// APB-style register file holding the framer configuration.
module shlf_cfg
  import shlf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output shlf_cfg_t          cfg
);

  shlf_cfg_t cfg_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_address <= LOCAL_ADDR_RST;
      cfg_r.down_address  <= DOWN_ADDR_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOCAL_ADDR: cfg_r.local_address <= pwdata[7:0];
        REG_DOWN_ADDR:  cfg_r.down_address  <= pwdata[7:0];
        REG_TIMEOUT:    cfg_r.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOCAL_ADDR: prdata = {24'd0, cfg_r.local_address};
      REG_DOWN_ADDR:  prdata = {24'd0, cfg_r.down_address};
      REG_TIMEOUT:    prdata = {16'd0, cfg_r.timeout_ticks};
      default:        prdata = '0;
    endcase
  end

endmodule

[design/shlf_engine.sv]
// Frame state machine, header checks, data count and tick timer.
`include "sync_header_length_framer_assert.svh"

module shlf_engine
  import shlf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  shlf_in_t  item,
  input  shlf_cfg_t cfg,
  output shlf_out_t result
);

  phase_t          phase_r, phase_nxt;
  logic [HC_W-1:0] header_count_r, header_count_nxt;
  logic            address_ok_r, address_ok_nxt;
  logic [7:0]      length_high_r, length_high_nxt;
  logic [15:0]     data_remaining_r, data_remaining_nxt;
  logic [15:0]     timer_count_r, timer_count_nxt;
  logic            timer_armed_r, timer_armed_nxt;

  logic [7:0]      b;
  logic            addr_ok_upd;
  logic [7:0]      len_hi_upd;
  logic            last_hdr;
  logic [15:0]     frame_len;

  assign b = item.data_byte;

  // address and length byte as they stand after this header byte
  always_comb begin
    addr_ok_upd = address_ok_r;
    len_hi_upd  = length_high_r;
    if (header_count_r == HC_W'(1) && b != cfg.down_address) addr_ok_upd = 1'b0;
    if (header_count_r == HC_W'(2) && b != cfg.local_address) addr_ok_upd = 1'b0;
    if (header_count_r == HC_W'(3)) len_hi_upd = b;
  end

  assign last_hdr  = header_count_r >= HC_W'(HEADER_BYTES - 1);
  assign frame_len = {len_hi_upd, b} + LEN_EXTRA;

  always_comb begin
    phase_nxt          = phase_r;
    header_count_nxt   = header_count_r;
    address_ok_nxt     = address_ok_r;
    length_high_nxt    = length_high_r;
    data_remaining_nxt = data_remaining_r;
    timer_count_nxt    = timer_count_r;
    timer_armed_nxt    = timer_armed_r;
    result.status       = ST_IGNORED;
    result.byte_out     = b;
    result.frame_length = '0;

    if (opcode_t'(item.opcode) == OP_TICK) begin
      result.byte_out = '0;
      if (timer_armed_r) begin
        if (timer_count_r <= 16'd1) begin
          timer_count_nxt = '0;
          timer_armed_nxt = 1'b0;
          phase_nxt       = PH_IDLE;
          result.status   = ST_TIMEOUT;
        end else begin
          timer_count_nxt = timer_count_r - 16'd1;
        end
      end
    end else begin
      unique case (phase_r)
        PH_HEAD: begin
          timer_count_nxt  = cfg.timeout_ticks;
          timer_armed_nxt  = 1'b1;
          address_ok_nxt   = addr_ok_upd;
          length_high_nxt  = len_hi_upd;
          header_count_nxt = header_count_r + HC_W'(1);
          result.status    = ST_HEADER;
          if (last_hdr) begin
            header_count_nxt = '0;
            if (!addr_ok_upd || len_hi_upd[7]) begin
              phase_nxt     = PH_IDLE;
              result.status = ST_REJECT;
            end else begin
              data_remaining_nxt  = frame_len;
              phase_nxt           = PH_DATA;
              result.frame_length = frame_len;
            end
          end
        end
        PH_DATA: begin
          if (data_remaining_r <= 16'd1) begin
            data_remaining_nxt = '0;
            phase_nxt          = PH_IDLE;
            timer_armed_nxt    = 1'b0;
            timer_count_nxt    = '0;
            result.status      = ST_DONE;
          end else begin
            data_remaining_nxt = data_remaining_r - 16'd1;
            result.status      = ST_DATA;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (b == SYNC_BYTE) begin
            phase_nxt          = PH_HEAD;
            header_count_nxt   = '0;
            address_ok_nxt     = 1'b1;
            length_high_nxt    = '0;
            data_remaining_nxt = '0;
            result.status      = ST_SYNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      header_count_r   <= '0;
      address_ok_r     <= 1'b1;
      length_high_r    <= '0;
      data_remaining_r <= '0;
      timer_count_r    <= '0;
      timer_armed_r    <= 1'b0;
    end else if (step_en) begin
      phase_r          <= phase_nxt;
      header_count_r   <= header_count_nxt;
      address_ok_r     <= address_ok_nxt;
      length_high_r    <= length_high_nxt;
      data_remaining_r <= data_remaining_nxt;
      timer_count_r    <= timer_count_nxt;
      timer_armed_r    <= timer_armed_nxt;
    end
  end

  `SHLF_ASSERT_ALWAYS(a_hdr_count_range, header_count_r < HC_W'(HEADER_BYTES), "header count overrun")
  `SHLF_ASSERT_ALWAYS(a_data_nonzero, phase_r != PH_DATA || data_remaining_r != 16'd0, "empty data count in data phase")
  `SHLF_ASSERT_ALWAYS(a_data_armed, phase_r != PH_DATA || timer_armed_r, "data phase without running timer")
  `SHLF_ASSERT_NEXT(a_done_idle, step_en && result.status == ST_DONE, phase_r == PH_IDLE && !timer_armed_r, "frame complete left block busy")

endmodule

[tb/shlf_frame_checker.sv]
// Checker for the sync header length framer: predicts each result beat and compares.
module shlf_frame_checker
  import shlf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  shlf_in_t           in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  shlf_out_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  cfg_local;
  logic [7:0]  cfg_down;
  logic [15:0] cfg_timeout;

  phase_t      rx_phase;
  logic [2:0]  hdr_idx;
  logic        addr_match;
  logic [7:0]  len_hi;
  logic [15:0] bytes_left;
  logic [15:0] tick_count;
  logic        tick_armed;

  shlf_out_t   frame_results_q[$];
  int          mismatches = 0;
  int          waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  task automatic advance_framer(input shlf_in_t beat, output shlf_out_t res);
    logic [7:0] b;
    logic [2:0] idx;
    b = beat.data_byte;
    res.status       = ST_IGNORED;
    res.byte_out     = 8'd0;
    res.frame_length = 16'd0;
    if (beat.opcode == OP_TICK) begin
      if (tick_armed) begin
        if (tick_count <= 16'd1) begin
          tick_count = 16'd0;
          tick_armed = 1'b0;
          rx_phase   = PH_IDLE;
          res.status = ST_TIMEOUT;
        end else begin
          tick_count = tick_count - 16'd1;
        end
      end
    end else begin
      res.byte_out = b;
      case (rx_phase)
        PH_HEAD: begin
          idx        = hdr_idx;
          tick_count = cfg_timeout;
          tick_armed = 1'b1;
          if (idx == 3'd1 && b != cfg_down) addr_match = 1'b0;
          if (idx == 3'd2 && b != cfg_local) addr_match = 1'b0;
          if (idx == 3'd3) len_hi = b;
          if (idx + 1 >= HEADER_BYTES) begin
            hdr_idx = 3'd0;
            if (!addr_match || len_hi[7]) begin
              rx_phase   = PH_IDLE;
              res.status = ST_REJECT;
            end else begin
              bytes_left       = {len_hi, b} + LEN_EXTRA;
              rx_phase         = PH_DATA;
              res.status       = ST_HEADER;
              res.frame_length = bytes_left;
            end
          end else begin
            hdr_idx    = idx + 3'd1;
            res.status = ST_HEADER;
          end
        end
        PH_DATA: begin
          if (bytes_left <= 16'd1) begin
            bytes_left = 16'd0;
            rx_phase   = PH_IDLE;
            tick_armed = 1'b0;
            tick_count = 16'd0;
            res.status = ST_DONE;
          end else begin
            bytes_left = bytes_left - 16'd1;
            res.status = ST_DATA;
          end
        end
        default: begin
          rx_phase = PH_IDLE;
          if (b == SYNC_BYTE) begin
            rx_phase   = PH_HEAD;
            hdr_idx    = 3'd0;
            addr_match = 1'b1;
            len_hi     = 8'd0;
            bytes_left = 16'd0;
            res.status = ST_SYNC;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    shlf_out_t want;
    if (!rst_n) begin
      cfg_local   = LOCAL_ADDR_RST;
      cfg_down    = DOWN_ADDR_RST;
      cfg_timeout = TIMEOUT_RST;
      rx_phase    = PH_IDLE;
      hdr_idx     = 3'd0;
      addr_match  = 1'b1;
      len_hi      = 8'd0;
      bytes_left  = 16'd0;
      tick_count  = 16'd0;
      tick_armed  = 1'b0;
      frame_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_LOCAL_ADDR: cfg_local   = pwdata[7:0];
          REG_DOWN_ADDR:  cfg_down    = pwdata[7:0];
          REG_TIMEOUT:    cfg_timeout = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: expected no result beat, got status %0d byte %02h len %0d",
                   $time, out_data.status, out_data.byte_out, out_data.frame_length);
          mismatches++;
        end else begin
          want = frame_results_q.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_data.status);
            mismatches++;
          end
          if (out_data.byte_out !== want.byte_out) begin
            $display("%0t: byte_out expected %02h got %02h", $time, want.byte_out,
                     out_data.byte_out);
            mismatches++;
          end
          if (out_data.frame_length !== want.frame_length) begin
            $display("%0t: frame_length expected %0d got %0d", $time, want.frame_length,
                     out_data.frame_length);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_framer(in_data, want);
        frame_results_q.push_back(want);
      end
    end
    waiting = frame_results_q.size();
  end

endmodule

[tb/sync_header_length_framer_tb.sv]
// Top of the framer testbench: clock, reset, stimulus, back-pressure and verdict.
module sync_header_length_framer_tb;
  import shlf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  shlf_in_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  shlf_out_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;

  // stimulus-side copy of the settings, used to build frames and to size the tick runs after cut frames
  logic [7:0] cur_local   = LOCAL_ADDR_RST;
  logic [7:0] cur_down    = DOWN_ADDR_RST;
  int         cur_timeout = TIMEOUT_RST;

  int   frame_beats = 0;   // sync, header and data beats sent in the random part
  logic calm      = 1'b0;  // no idling on either side once set
  logic hold_go   = 1'b0;  // asks the receiver for one long hold-off
  logic hold_done = 1'b0;

  sync_header_length_framer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  shlf_frame_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: well beyond the slowest legal run (every beat gapped and stalled).
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver side. Random stall bursts, plus one long hold-off
  // while the sender keeps offering beats, so the pipe fills and in_ready drops.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // All tasks start and end just after a rising edge. in_valid stays high
  // between back-to-back beats; it only drops for an idle burst or in settle.
  task automatic send_beat(input opcode_t op, input logic [7:0] b);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.opcode    <= op;
    in_data.data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // tick payload is don't-care for the block, so randomise it
  task automatic send_tick();
    send_beat(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Stop offering, wait for every outstanding result, then idle on
  // so the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup then access; transfers run back to back.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // bits above the register width are junk the block must drop
    pwdata  <= {16'($urandom_range(0, 65535)),
                (idx == REG_TIMEOUT) ? val : {8'($urandom_range(0, 255)), val[7:0]}};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] lc, input logic [7:0] dn, input logic [15:0] tmo);
    write_reg(REG_LOCAL_ADDR, {8'd0, lc});
    write_reg(REG_DOWN_ADDR, {8'd0, dn});
    write_reg(REG_TIMEOUT, tmo);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_local   = lc;
    cur_down    = dn;
    cur_timeout = tmo;
  endtask

  // One frame: sync, five header bytes, then length+2 data bytes when the
  // header is good. Ticks are sprinkled in; cut >= 0 truncates the frame.
  task automatic send_frame(input bit bad_addr, input bit neg_len, input int cut);
    logic [7:0] addr_dn;
    logic [7:0] addr_lc;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] b;
    int         total;
    addr_dn = cur_down;
    addr_lc = cur_local;
    hi      = 8'd0;
    lo      = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 24));
    if (bad_addr) begin
      if ($urandom_range(0, 1) == 1) addr_dn = cur_down ^ 8'($urandom_range(1, 255));
      else addr_lc = cur_local ^ 8'($urandom_range(1, 255));
    end
    if (neg_len) begin
      hi = 8'($urandom_range(128, 255));
      lo = 8'($urandom_range(0, 255));
    end
    total = (bad_addr || neg_len) ? 6 : 8 + int'({hi, lo});
    for (int pos = 0; pos < total; pos++) begin
      if (cut >= 0 && pos >= cut) break;
      case (pos)
        0:       b = SYNC_BYTE;
        2:       b = addr_dn;
        3:       b = addr_lc;
        4:       b = hi;
        5:       b = lo;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 9) == 0) send_tick();
      send_beat(OP_BYTE, b);
      frame_beats++;
    end
  endtask

  initial begin
    logic [8:0] seq[];
    int         tmo;
    logic [7:0] same_addr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings (addresses 255, long timeout): tick while the
    // timer is disarmed, a stray byte, then the shortest good frame.
    seq = '{{OP_TICK, 8'h00}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'hFF},
            {OP_BYTE, 8'hFF}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'hFF},
            {OP_BYTE, 8'h00}, {OP_BYTE, 8'h00},
            {OP_BYTE, 8'h5A}, {OP_BYTE, 8'hA5}, {OP_TICK, 8'hFF}};
    foreach (seq[k]) send_beat(opcode_t'(seq[k][8]), seq[k][7:0]);
    settle();

    // Directed, zero timeout: sync leaves the timer alone; a negative length
    // rejects yet keeps the timer running, so it still fires after a new sync;
    // the longest legal length, then expiry in the data phase.
    configure(8'h00, 8'hFF, 16'd0);
    seq = '{{OP_BYTE, 8'hFF}, {OP_TICK, 8'h55},
            {OP_BYTE, 8'h11}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'h00},
            {OP_BYTE, 8'h80}, {OP_BYTE, 8'h00},
            {OP_BYTE, 8'hFF}, {OP_TICK, 8'hAA}, {OP_BYTE, 8'h33},
            {OP_BYTE, 8'hFF}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'h00},
            {OP_BYTE, 8'h7F}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'h01}, {OP_TICK, 8'h00}};
    foreach (seq[k]) send_beat(opcode_t'(seq[k][8]), seq[k][7:0]);

    // Random part: mostly good frames, some noise, bad headers and frames cut
    // short, then ticks that time them out if timeout <= 40. Settings change between phases.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0:       tmo = 65535;
        1:       tmo = 1;
        5:       tmo = $urandom_range(8, 40);
        default: tmo = $urandom_range(2, 40);
      endcase
      if (ph == 1) configure(8'hFF, 8'h00, 16'(tmo));
      else if ($urandom_range(0, 1) == 1) configure(8'($urandom_range(0, 255)),
                                                    8'($urandom_range(0, 255)), 16'(tmo));
      else begin
        // both addresses equal
        same_addr = 8'($urandom_range(0, 255));
        configure(same_addr, same_addr, 16'(tmo));
      end
      if (ph == 0) hold_go <= 1'b1;
      if (ph == 5) calm <= 1'b1;
      frame_beats = 0;
      while (frame_beats < 150) begin
        case ($urandom_range(0, 9))
          7: begin
            repeat ($urandom_range(1, 6)) begin
              if ($urandom_range(0, 1) == 1) send_tick();
              else send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
            end
          end
          8: begin
            if ($urandom_range(0, 1) == 1) send_frame(1'b1, 1'b0, -1);
            else send_frame(1'b0, 1'b1, -1);
          end
          9: begin
            send_frame(1'b0, 1'b0, $urandom_range(1, 8));
            repeat ((cur_timeout <= 40) ? cur_timeout + 1 : 3) send_tick();
          end
          default: send_frame(1'b0, 1'b0, -1);
        endcase
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
